// ===== sv/qrs_pkg.sv =====
// qrs_pkg: shared widths, types and constants of the quadratic root solver
// no dependencies; imported by every qrs module
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
    localparam int CoefW  = 16;
    localparam int DiscW  = 34;   // b*b - 4*a*c, signed, |D| < 2^33
    localparam int SqrtW  = 17;   // floor root of a value below 2^33
    localparam int NumW   = 19;   // -b +/- s, signed
    localparam int DivW   = 35;   // |n| * 2^16, magnitude below 2^35
    localparam int DenW   = 17;   // |2a|
    localparam int RootW  = 40;

    localparam logic [1:0] CntNone   = 2'd0;
    localparam logic [1:0] CntDouble = 2'd1;
    localparam logic [1:0] CntTwo    = 2'd2;

    // item flags carried beside the data through the pipeline
    typedef struct packed {
        logic       bad;
        logic [1:0] cnt;
    } t_flags;

    // flags, a and b travelling beside the radicand
    localparam int SideW = 2*CoefW + $bits(t_flags);
endpackage
`default_nettype wire

// ===== sv/qrs_sqrt.sv =====
// qrs_sqrt: pipelined floor square root, one result bit per stage
// depends on qrs_pkg; carries side payload beside the radicand
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [qrs_pkg::DiscW-2:0]     i_rad,
    input  wire logic [qrs_pkg::SideW-1:0]     i_side,
    output logic                               o_vld,
    output logic [qrs_pkg::SqrtW-1:0]          o_root,
    output logic [qrs_pkg::SideW-1:0]          o_side
);
    import qrs_pkg::*;

    localparam int RadW = DiscW - 1;
    localparam int SW   = SideW;
    logic [RadW-1:0]  r_rem  [SqrtW+1];
    logic [SqrtW-1:0] r_res  [SqrtW+1];
    logic [SW-1:0]    r_side [SqrtW+1];
    logic             r_vld  [SqrtW+1];

    always_comb begin
        r_rem[0]  = i_rad;
        r_res[0]  = '0;
        r_side[0] = i_side;
        r_vld[0]  = i_vld;
    end

    // stage k decides result bit SqrtW-1-k: trial = res << (bit position + 1) | 1 << (2 * bit position)
    for (genvar k = 0; k < SqrtW; k++) begin : g_stage
        localparam int Bp = SqrtW - 1 - k;
        logic [RadW+1:0]  n_trial;
        logic [RadW-1:0]  n_rem;
        logic [SqrtW-1:0] n_res;
        logic [RadW-1:0]  r_rem_q;
        logic [SqrtW-1:0] r_res_q;
        logic [SW-1:0]    r_side_q;
        logic             r_vld_q;
        always_comb begin
            n_trial = ({{(RadW+2-SqrtW){1'b0}}, r_res[k]} << (Bp + 1))
                    | ((RadW+2)'(1) << (2*Bp));
            n_rem = r_rem[k];
            n_res = r_res[k];
            if ({2'b00, r_rem[k]} >= n_trial) begin
                n_rem = r_rem[k] - n_trial[RadW-1:0];
                n_res = r_res[k] | (SqrtW'(1) << Bp);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_q <= 1'b0;
            end else if (i_en) begin
                r_vld_q <= r_vld[k];
            end
            if (i_en) begin
                r_rem_q  <= n_rem;
                r_res_q  <= n_res;
                r_side_q <= r_side[k];
            end
        end
        always_comb begin
            r_rem[k+1]  = r_rem_q;
            r_res[k+1]  = r_res_q;
            r_side[k+1] = r_side_q;
            r_vld[k+1]  = r_vld_q;
        end
    end

    assign o_vld  = r_vld[SqrtW];
    assign o_root = r_res[SqrtW];
    assign o_side = r_side[SqrtW];
endmodule
`default_nettype wire

// ===== sv/qrs_div.sv =====
// qrs_div: pipelined restoring divider, two quotients sharing one divisor
// depends on qrs_pkg; one quotient bit per stage, magnitudes only
`timescale 1ns / 1ps
`default_nettype none
module qrs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [qrs_pkg::DivW-1:0]   i_num_p,
    input  wire logic [qrs_pkg::DivW-1:0]   i_num_m,
    input  wire logic [qrs_pkg::DenW-1:0]   i_den,
    input  wire logic [4:0]                 i_side,
    output logic                            o_vld,
    output logic [qrs_pkg::DivW-1:0]        o_quo_p,
    output logic [qrs_pkg::DivW-1:0]        o_quo_m,
    output logic [4:0]                      o_side
);
    import qrs_pkg::*;

    logic [DivW-1:0] r_np [DivW+1];
    logic [DivW-1:0] r_nm [DivW+1];
    logic [DenW-1:0] r_rp [DivW+1];
    logic [DenW-1:0] r_rm [DivW+1];
    logic [DenW-1:0] r_d  [DivW+1];
    logic [4:0]      r_s  [DivW+1];
    logic            r_v  [DivW+1];

    always_comb begin
        r_np[0] = i_num_p;
        r_nm[0] = i_num_m;
        r_rp[0] = '0;
        r_rm[0] = '0;
        r_d[0]  = i_den;
        r_s[0]  = i_side;
        r_v[0]  = i_vld;
    end

    // numerator word shifts left; its top bit enters the partial remainder,
    // the quotient bit fills the freed low bit
    for (genvar k = 0; k < DivW; k++) begin : g_stage
        logic [DenW:0]   n_tp, n_tm;
        logic [DivW-1:0] n_np, n_nm;
        logic [DenW-1:0] n_rp, n_rm;
        logic [DivW-1:0] q_np, q_nm;
        logic [DenW-1:0] q_rp, q_rm, q_d;
        logic [4:0]      q_s;
        logic            q_v;
        always_comb begin
            n_tp = {r_rp[k], r_np[k][DivW-1]};
            n_tm = {r_rm[k], r_nm[k][DivW-1]};
            n_np = {r_np[k][DivW-2:0], 1'b0};
            n_nm = {r_nm[k][DivW-2:0], 1'b0};
            n_rp = n_tp[DenW-1:0];
            n_rm = n_tm[DenW-1:0];
            if (n_tp >= {1'b0, r_d[k]}) begin
                n_rp    = DenW'(n_tp - {1'b0, r_d[k]});
                n_np[0] = 1'b1;
            end
            if (n_tm >= {1'b0, r_d[k]}) begin
                n_rm    = DenW'(n_tm - {1'b0, r_d[k]});
                n_nm[0] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                q_v <= 1'b0;
            end else if (i_en) begin
                q_v <= r_v[k];
            end
            if (i_en) begin
                q_np <= n_np;
                q_nm <= n_nm;
                q_rp <= n_rp;
                q_rm <= n_rm;
                q_d  <= r_d[k];
                q_s  <= r_s[k];
            end
        end
        always_comb begin
            r_np[k+1] = q_np;
            r_nm[k+1] = q_nm;
            r_rp[k+1] = q_rp;
            r_rm[k+1] = q_rm;
            r_d[k+1]  = q_d;
            r_s[k+1]  = q_s;
            r_v[k+1]  = q_v;
        end
    end

    assign o_vld   = r_v[DivW];
    assign o_quo_p = r_np[DivW];
    assign o_quo_m = r_nm[DivW];
    assign o_side  = r_s[DivW];
endmodule
`default_nettype wire

// ===== sv/quadratic_root_solver_unit.sv =====
// quadratic_root_solver_unit: real roots of a*x^2+b*x+c in fixed point
// depends on qrs_pkg, qrs_sqrt and qrs_div
//
// channel  dir  fields (tdata from bit 0 up)
// s_axis   in   coef_a[15:0] coef_b[31:16] coef_c[47:32]
// m_axis   out  root_count[1:0] root_plus[41:2] root_minus[81:42] bad_coef[82], pad to 88
//
// 2 + 17 + 1 + 35 + 1 = 56 register stages; one transaction per cycle
// while the output register is empty or taken
// the depth is set by the bit-serial root stages and the quotient stages
// reset clears the valid bits only; payload registers are not reset
// the whole pipeline advances when the output register is empty or taken
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata    // root_count, root_plus, root_minus, bad_coef
);
    import qrs_pkg::*;

    logic w_en;
    logic r_ov;
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: products
    logic signed [CoefW-1:0] w_a, w_b, w_c;
    assign w_a = s_axis_tdata[15:0];
    assign w_b = s_axis_tdata[31:16];
    assign w_c = s_axis_tdata[47:32];

    logic                    r1_v;
    logic signed [31:0]      r1_bb, r1_ac;
    logic signed [CoefW-1:0] r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
        end
        if (w_en) begin
            r1_bb <= w_b * w_b;
            r1_ac <= w_a * w_c;
            r1_a  <= w_a;
            r1_b  <= w_b;
        end
    end

    // stage 2: discriminant and its sign class
    logic signed [DiscW-1:0] n2_d;
    assign n2_d = DiscW'(r1_bb) - (DiscW'(r1_ac) <<< 2);
    logic               r2_v;
    logic [DiscW-2:0]   r2_rad;
    logic [SideW-1:0]   r2_side;
    t_flags             n2_f;
    always_comb begin
        n2_f.bad = (r1_a == '0);
        if (n2_f.bad || n2_d < 0) n2_f.cnt = CntNone;
        else if (n2_d == 0)       n2_f.cnt = CntDouble;
        else                      n2_f.cnt = CntTwo;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_rad  <= (n2_d > 0) ? n2_d[DiscW-2:0] : '0;
            r2_side <= {n2_f, r1_a, r1_b};
        end
    end

    logic               w_sv;
    logic [SqrtW-1:0]   w_s;
    logic [SideW-1:0]   w_sside;
    qrs_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_vld (r2_v), .i_rad (r2_rad), .i_side (r2_side),
        .o_vld (w_sv), .o_root (w_s), .o_side (w_sside)
    );

    // stage 3: numerators and divisor as magnitudes, signs kept aside
    t_flags                  w_f3;
    logic signed [CoefW-1:0] w_a3, w_b3;
    assign {w_f3, w_a3, w_b3} = w_sside;
    logic signed [NumW-1:0] n3_np, n3_nm;
    logic [DenW-1:0]        n3_den;
    assign n3_np  = -NumW'(w_b3) + NumW'($signed({1'b0, w_s}));
    assign n3_nm  = -NumW'(w_b3) - NumW'($signed({1'b0, w_s}));
    assign n3_den = w_a3[CoefW-1] ? DenW'(-(DenW'(w_a3)) <<< 1) : DenW'({w_a3, 1'b0});
    logic            r3_v;
    logic [DivW-1:0] r3_np, r3_nm;
    logic [DenW-1:0] r3_den;
    logic [4:0]      r3_side;   // sign plus, sign minus, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_sv;
        end
        if (w_en) begin
            r3_np   <= DivW'(n3_np[NumW-1] ? -n3_np : n3_np) << 16;
            r3_nm   <= DivW'(n3_nm[NumW-1] ? -n3_nm : n3_nm) << 16;
            r3_den  <= w_f3.bad ? DenW'(1) : n3_den;
            r3_side <= {n3_np[NumW-1] ^ w_a3[CoefW-1], n3_nm[NumW-1] ^ w_a3[CoefW-1], w_f3};
        end
    end

    logic            w_qv;
    logic [DivW-1:0] w_qp, w_qm;
    logic [4:0]      w_qside;
    qrs_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_vld (r3_v), .i_num_p (r3_np), .i_num_m (r3_nm), .i_den (r3_den),
        .i_side (r3_side),
        .o_vld (w_qv), .o_quo_p (w_qp), .o_quo_m (w_qm), .o_side (w_qside)
    );

    // output register: apply signs and zero the unused roots
    t_flags w_fo;
    assign w_fo = w_qside[2:0];
    logic [RootW-1:0] n_rp, n_rm;
    always_comb begin
        n_rp = w_qside[4] ? -RootW'(w_qp) : RootW'(w_qp);
        n_rm = w_qside[3] ? -RootW'(w_qm) : RootW'(w_qm);
        if (w_fo.cnt == CntNone) n_rp = '0;
        if (w_fo.cnt != CntTwo)  n_rm = '0;
    end
    logic [82:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_qv;
        end
        if (w_en) begin
            r_od <= {w_fo.bad, n_rm, n_rp, w_fo.cnt};
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b0, r_od};

    a_bad_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[82] |-> m_axis_tdata[81:0] == '0)
        else $error("bad coefficient with roots");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("root count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== tb/quadratic_root_solver_unit_tb.sv =====
// quadratic_root_solver_unit_tb: self-checking bench for the quadratic root solver
// depends on qrs_pkg and quadratic_root_solver_unit; a scoreboard class predicts each root set
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic [1:0]  cnt;
    logic [39:0] rplus;
    logic [39:0] rminus;
    logic        bad;
} t_roots;

class roots_scoreboard;
    t_roots pending[$];
    int     n_err;

    function logic [39:0] quot_q16(longint num, longint den);
        longint q;
        q = (num * 65536) / den;   // signed division truncates toward zero
        return q[39:0];
    endfunction

    function longint floor_sqrt(longint x);
        longint r;
        longint bitv;
        r = 0;
        bitv = 64'sd1 << 62;
        while (bitv > x) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >>> 1) + bitv;
            end else begin
                r = r >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return r;
    endfunction

    function void note_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                             logic signed [15:0] cc);
        t_roots e;
        longint a, b, c, d, s;
        a = ca; b = cb; c = cc;
        e.cnt = qrs_pkg::CntNone; e.rplus = '0; e.rminus = '0; e.bad = 1'b0;
        if (a == 0) begin
            e.bad = 1'b1;
        end else begin
            d = b * b - 4 * a * c;
            if (d > 0) begin
                s = floor_sqrt(d);
                e.cnt = qrs_pkg::CntTwo;
                e.rplus = quot_q16(-b + s, 2 * a);
                e.rminus = quot_q16(-b - s, 2 * a);
            end else if (d == 0) begin
                e.cnt = qrs_pkg::CntDouble;
                e.rplus = quot_q16(-b, 2 * a);
            end
        end
        pending.push_back(e);
    endfunction

    function void report(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_err++;
    endfunction

    function void check_roots(logic [87:0] td);
        t_roots e;
        if (pending.size() == 0) begin
            report("unexpected transaction", td[41:2], '0);
            return;
        end
        e = pending.pop_front();
        if (td[1:0] !== e.cnt) report("root_count", td[1:0], e.cnt);
        if (td[41:2] !== e.rplus) report("root_plus", td[41:2], e.rplus);
        if (td[81:42] !== e.rminus) report("root_minus", td[81:42], e.rminus);
        if (td[82] !== e.bad) report("bad_coef", td[82], e.bad);
    endfunction
endclass

module quadratic_root_solver_unit_tb;
    import qrs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    roots_scoreboard sb = new();
    int  cycles = 0;
    int  sink_hold = 0;
    bit  stim_done = 1'b0;
    bit  quiet_sink = 1'b0;

    always #10 i_clk = ~i_clk;

    quadratic_root_solver_unit dut (.*);

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_coefs(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc, int gap);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cc, cb, ca};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_coefs(ca, cb, cc);
    endtask

    // random coefficient with bias toward edges and small values
    function logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000 | 16'($urandom_range(0, 3));
            1: return 16'h7fff - 16'($urandom_range(0, 3));
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3: return 16'($signed($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // sink: stalls of random length, always ready during the quiet stretch
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_roots(m_axis_tdata);
        if (quiet_sink) begin
            m_axis_tready <= 1'b1;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] a, b, c, r;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: a zero, extremes, each discriminant sign, tiny positive
        send_coefs(16'h0000, 16'h1234, 16'h0100, 0);
        send_coefs(16'h0100, 16'h0000, 16'hff00, 0);  // two roots
        send_coefs(16'h0100, 16'h0200, 16'h0100, 0);  // double root
        send_coefs(16'h0100, 16'h0000, 16'h0100, 0);  // no root
        send_coefs(16'h0001, 16'h0001, 16'h0000, 0);  // tiny positive d=1
        send_coefs(16'h0004, 16'h0003, 16'h0000, 1);
        send_coefs(16'h7fff, 16'h8000, 16'h8000, 0);
        send_coefs(16'h8000, 16'h8000, 16'h7fff, 0);
        send_coefs(16'h8000, 16'h7fff, 16'h8000, 2);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_coefs(16'hffff, 16'hffff, 16'hffff, 0);
        send_coefs(16'h0001, 16'h8000, 16'h8000, 0);
        send_coefs(16'hffff, 16'h8000, 16'h7fff, 0);
        send_coefs(16'h0000, 16'h0000, 16'h0000, 0);
        send_coefs(16'hfe00, 16'h0400, 16'hfe00, 0);  // double root, negative a
        send_coefs(16'h5555, 16'haaaa, 16'h5555, 0);
        send_coefs(16'haaaa, 16'h5555, 16'haaaa, 0);
        for (k = 0; k < 400; k++) begin
            quiet_sink = (k >= 150 && k < 220);
            a = rand_coef();
            if ($urandom_range(0, 30) == 0) a = '0;
            b = rand_coef();
            c = rand_coef();
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // perfect square: b = 2*a*m-ish, c = b*b/(4a) near zero discriminant
                a = 16'($urandom_range(1, 64));
                b = 16'(2 * a * $urandom_range(0, 8));
                c = 16'(b * b / (4 * a));
            end
            send_coefs(a, b, c, (k < 60) ? 0 : pick_gap());
        end
        s_axis_tvalid <= 1'b0;
        quiet_sink = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
